### hdl/pfa_pkg.sv
// Package for the partition fit allocator: codes and widths.
// No dependencies.
package pfa_pkg;
	localparam int MAX_PARTS_DEF = 16;
	localparam int SIZE_BITS_DEF = 16;
	localparam int OWNER_W = 8;

	typedef enum logic [1:0] {
		FN_APPEND  = 2'd0,
		FN_ALLOC   = 2'd1,
		FN_RELEASE = 2'd2,
		FN_MERGE   = 2'd3
	} func_t;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FIT    = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Command broadcast from the sequencer to every cell.
	typedef enum logic [3:0] {
		OP_NONE  = 4'b0001,
		OP_SHIFT = 4'b0010,
		OP_FREE  = 4'b0100,
		OP_CLAIM = 4'b1000
	} op_t;
endpackage

### hdl/pfa_cell.sv
// One table entry of the partition fit allocator.
// Depends on pfa_pkg.
module pfa_cell #(
	parameter int SIZE_BITS = 16,
	parameter int IDX_W = 4
) (
	input  logic                 clk,
	input  logic [3:0]           op,
	input  logic [IDX_W-1:0]     my_idx,
	input  logic [IDX_W-1:0]     sel_idx,
	input  logic [IDX_W-1:0]     wr_idx,
	input  logic                 wr_en,
	input  logic [SIZE_BITS-1:0] wr_size,
	input  logic                 wr_free,
	input  logic [pfa_pkg::OWNER_W-1:0] wr_owner,
	input  logic [SIZE_BITS-1:0] prev_size,
	input  logic                 prev_free,
	input  logic [pfa_pkg::OWNER_W-1:0] prev_owner,
	input  logic [pfa_pkg::OWNER_W-1:0] rel_owner,
	output logic [SIZE_BITS-1:0] size,
	output logic                 free,
	output logic [pfa_pkg::OWNER_W-1:0] owner,
	output logic                 rel_hit
);
	import pfa_pkg::*;

	logic [SIZE_BITS-1:0] size_q;
	logic                 free_q;
	logic [OWNER_W-1:0]   owner_q;

	assign size = size_q;
	assign free = free_q;
	assign owner = owner_q;
	assign rel_hit = !free_q && (owner_q == rel_owner);

	// Take a direct write first, else neighbor data on shift, else free the entry on a release match.
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == my_idx) begin
			size_q <= wr_size;
			free_q <= wr_free;
			owner_q <= wr_owner;
		end else if (op == OP_SHIFT && my_idx > sel_idx) begin
			size_q <= prev_size;
			free_q <= prev_free;
			owner_q <= prev_owner;
		end else if (op == OP_FREE && rel_hit) begin
			free_q <= 1'b1;
			owner_q <= '0;
		end
	end
endmodule

### hdl/partition_fit_allocator_top.sv
// Top level of the partition fit allocator: sequencer over a row of cells.
// Depends on pfa_pkg and pfa_cell.
//
// One transaction at a time. Append and release pass from the scan state to
// the done state. Allocate scans one entry per cycle: first fit stops at the
// first fitting entry, while best and worst fit and a failed search walk the
// whole table. A split passes through a shift state before the done state.
// Merge walks the table one entry per cycle with a read and a write pointer.
// The table is a row of cells. A split shifts all cells above the chosen
// entry one place up in the shift state through the neighbor links, and the
// remainder entry is written in the done state. The result sits in an output
// register, and the next transaction is taken only once the result has been
// accepted.
module partition_fit_allocator_top #(
	parameter int MAX_PARTS = pfa_pkg::MAX_PARTS_DEF,
	parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  fit_mode,
	input  logic [15:0] req_size,
	input  logic [7:0]  owner_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status_code,
	output logic [3:0]  segment_index,
	output logic [4:0]  segment_count,
	output logic [4:0]  freed_count
);
	import pfa_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARTS);
	localparam int CNT_W = $clog2(MAX_PARTS + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_PARTS);
	localparam logic [SIZE_BITS-1:0] SMAX = '1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SPLIT = 5'b00100,
		S_MERGE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic [1:0] func_q, mode_q;
	logic [SIZE_BITS-1:0] want_q;
	logic [OWNER_W-1:0] own_q;
	logic [CNT_W-1:0] cnt_q, ptr_q, wptr_q;
	logic found_q;
	logic [IDX_W-1:0] pick_q;
	logic [SIZE_BITS-1:0] psize_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic rem_wr_q;
	logic [IDX_W-1:0] rem_idx;

	logic [SIZE_BITS-1:0] c_size [MAX_PARTS];
	logic                 c_free [MAX_PARTS];
	logic [OWNER_W-1:0]   c_owner [MAX_PARTS];
	logic [MAX_PARTS-1:0] c_hit;

	logic [3:0] op;
	logic wr_en, wr_free;
	logic [IDX_W-1:0] wr_idx, sel_idx;
	logic [SIZE_BITS-1:0] wr_size;
	logic [OWNER_W-1:0] wr_owner;

	// Cell row; each cell above the first links to its lower neighbor.
	for (genvar g = 0; g < MAX_PARTS; g++) begin : g_cell
		if (g == 0) begin : g_first
			pfa_cell #(.SIZE_BITS(SIZE_BITS), .IDX_W(IDX_W)) u_cell (
				.clk, .op, .my_idx(IDX_W'(g)), .sel_idx, .wr_idx, .wr_en,
				.wr_size, .wr_free, .wr_owner,
				.prev_size(c_size[0]), .prev_free(c_free[0]),
				.prev_owner(c_owner[0]), .rel_owner(own_q),
				.size(c_size[g]), .free(c_free[g]), .owner(c_owner[g]),
				.rel_hit(c_hit[g]));
		end else begin : g_rest
			pfa_cell #(.SIZE_BITS(SIZE_BITS), .IDX_W(IDX_W)) u_cell (
				.clk, .op, .my_idx(IDX_W'(g)), .sel_idx, .wr_idx, .wr_en,
				.wr_size, .wr_free, .wr_owner,
				.prev_size(c_size[g-1]), .prev_free(c_free[g-1]),
				.prev_owner(c_owner[g-1]), .rel_owner(own_q),
				.size(c_size[g]), .free(c_free[g]), .owner(c_owner[g]),
				.rel_hit(c_hit[g]));
		end
	end

	// Count release matches among live entries.
	logic [CNT_W-1:0] rel_n;
	always_comb begin
		rel_n = '0;
		for (int i = 0; i < MAX_PARTS; i++)
			if (c_hit[i] && CNT_W'(i) < cnt_q)
				rel_n = rel_n + CNT_W'(1);
	end
	logic [MAX_PARTS-1:0] live;
	always_comb
		for (int i = 0; i < MAX_PARTS; i++) live[i] = CNT_W'(i) < cnt_q;

	// Scan and merge read ports.
	logic [IDX_W-1:0] rp, wm1;
	assign rp = ptr_q[IDX_W-1:0];
	assign wm1 = IDX_W'(wptr_q - CNT_W'(1));
	logic [SIZE_BITS-1:0] s_size;
	logic s_free;
	logic [OWNER_W-1:0] s_owner;
	assign s_size = c_size[rp];
	assign s_free = c_free[rp];
	assign s_owner = c_owner[rp];
	logic [SIZE_BITS:0] msum;
	assign msum = {1'b0, c_size[wm1]} + {1'b0, s_size};

	logic s_fit, s_take;
	assign s_fit = s_free && s_size >= want_q;
	always_comb begin
		s_take = 1'b0;
		if (s_fit) begin
			if (!found_q) s_take = 1'b1;
			else if (mode_q == MODE_BEST) s_take = s_size < psize_q;
			else if (mode_q == MODE_WORST) s_take = s_size > psize_q;
		end
	end
	logic scan_stop;
	assign scan_stop = ptr_q >= cnt_q ||
		(s_fit && !found_q && mode_q != MODE_BEST && mode_q != MODE_WORST);

	logic res_v_q;
	logic [1:0] st_q;
	logic [3:0] idx_q;
	logic [4:0] fr_q;

	assign in_stall = state_q != S_IDLE || res_v_q;
	assign out_valid = res_v_q;
	assign status_code = st_q;
	assign segment_index = idx_q;
	assign segment_count = 5'(cnt_q);
	assign freed_count = fr_q;

	// Remainder entry lands one above the pick after the shift.
	assign rem_idx = pick_q + IDX_W'(1);

	// Cell commands.
	always_comb begin
		op = OP_NONE;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_size = '0;
		wr_free = 1'b0;
		wr_owner = '0;
		sel_idx = pick_q;
		unique case (state_q)
			S_IDLE: ;
			S_SCAN: begin
				if (func_q == FN_APPEND && cnt_q < FULL) begin
					wr_en = 1'b1;
					wr_idx = IDX_W'(cnt_q);
					wr_size = want_q;
					wr_free = 1'b1;
				end else if (func_q == FN_RELEASE) begin
					op = OP_FREE;
				end else if (func_q == FN_ALLOC && scan_stop) begin
					if (found_q || (ptr_q < cnt_q && s_fit)) begin
						wr_idx = (ptr_q < cnt_q && s_take) ? rp : pick_q;
						if (!((ptr_q < cnt_q && s_take) ? s_size > want_q
							: psize_q > want_q)) begin
							wr_en = 1'b1;
							wr_size = want_q;
							wr_owner = own_q;
						end
					end
				end
			end
			S_SPLIT: begin
				op = OP_SHIFT;
				wr_en = 1'b1;
				wr_idx = pick_q;
				wr_size = want_q;
				wr_owner = own_q;
			end
			S_MERGE: begin
				if (ptr_q < cnt_q) begin
					wr_en = 1'b1;
					if (wptr_q != '0 && s_free && c_free[wm1]) begin
						wr_idx = wm1;
						wr_size = msum[SIZE_BITS] ? SMAX : msum[SIZE_BITS-1:0];
						wr_free = 1'b1;
					end else begin
						wr_idx = IDX_W'(wptr_q);
						wr_size = s_size;
						wr_free = s_free;
						wr_owner = s_owner;
					end
				end
			end
			S_DONE: begin
				if (rem_wr_q) begin
					wr_en = 1'b1;
					wr_idx = rem_idx;
					wr_size = rem_q;
					wr_free = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_v_q && !out_stall) res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						func_q <= func;
						mode_q <= fit_mode;
						want_q <= SIZE_BITS'(req_size);
						own_q <= owner_id;
						ptr_q <= '0;
						wptr_q <= '0;
						found_q <= 1'b0;
						pick_q <= '0;
						st_q <= ST_OK;
						idx_q <= '0;
						fr_q <= '0;
						state_q <= (func == FN_MERGE) ? S_MERGE : S_SCAN;
					end
				end
				S_SCAN: begin
					unique case (func_q)
						FN_APPEND: begin
							if (cnt_q < FULL) begin
								idx_q <= 4'(cnt_q);
								cnt_q <= cnt_q + CNT_W'(1);
							end else st_q <= ST_FULL;
							state_q <= S_DONE;
						end
						FN_RELEASE: begin
							fr_q <= 5'(rel_n);
							if (rel_n == '0) st_q <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end
						FN_ALLOC: begin
							if (ptr_q < cnt_q && s_take) begin
								found_q <= 1'b1;
								pick_q <= rp;
								psize_q <= s_size;
							end
							ptr_q <= ptr_q + CNT_W'(1);
							if (scan_stop) begin
								if (!(found_q || (ptr_q < cnt_q && s_fit))) begin
									st_q <= ST_NO_FIT;
									state_q <= S_DONE;
								end else if (wr_en) begin
									idx_q <= 4'(wr_idx);
									state_q <= S_DONE;
								end else if (cnt_q >= FULL) begin
									st_q <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									rem_q <= ((ptr_q < cnt_q && s_take) ? s_size
										: psize_q) - want_q;
									state_q <= S_SPLIT;
								end
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SPLIT: begin
					idx_q <= 4'(pick_q);
					cnt_q <= cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_MERGE: begin
					if (ptr_q < cnt_q) begin
						ptr_q <= ptr_q + CNT_W'(1);
						if (!(wptr_q != '0 && s_free && c_free[wm1]))
							wptr_q <= wptr_q + CNT_W'(1);
					end else begin
						cnt_q <= wptr_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					res_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Flag the remainder write for the cycle after the shift.
	always_ff @(posedge clk or negedge arst_n)
		if (!arst_n) rem_wr_q <= 1'b0;
		else rem_wr_q <= state_q == S_SPLIT;

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL) else $error("count beyond capacity");
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live) == int'(cnt_q)) else $error("live mask mismatch");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid |-> in_stall)) else $error("accepted while result pending");
endmodule
